FILE: rtl/itt_pkg.sv
// itt_pkg: shared types and constants of the indent tree tokenizer.
// Used by the channel interfaces and the top level.
// No dependencies.
package itt_pkg;

    // Code point and event field widths
    localparam int CP_W    = 21;
    localparam int KIND_W  = 2;
    localparam int DEPTH_W = 5;
    localparam int WHITE_W = 16;

    // Indent stack geometry
    localparam int MAX_DEPTH = 16;
    localparam int LVL_W     = $clog2(MAX_DEPTH + 1);
    localparam int ADDR_W    = $clog2(MAX_DEPTH);

    // Output queue, depth must be a power of two
    localparam int FIFO_DEPTH = 4;
    localparam int FPTR_W     = $clog2(FIFO_DEPTH);
    localparam int FCNT_W     = $clog2(FIFO_DEPTH + 1);

    localparam logic [WHITE_W-1:0] WHITE_MAX = '1;

    // Characters of interest
    localparam logic [CP_W-1:0] CH_NL   = CP_W'(32'h0A);
    localparam logic [CP_W-1:0] CH_SP   = CP_W'(32'h20);
    localparam logic [CP_W-1:0] CH_HASH = CP_W'(32'h23);
    localparam logic [CP_W-1:0] CH_DQ   = CP_W'(32'h22);
    localparam logic [CP_W-1:0] CH_BT   = CP_W'(32'h60);

    typedef enum logic [KIND_W-1:0] {
        EV_NODE_BEGIN  = 2'd0,
        EV_TOKEN_BEGIN = 2'd1,
        EV_TOKEN_CHAR  = 2'd2,
        EV_TOKEN_END   = 2'd3
    } t_event_kind;

    typedef enum logic [2:0] {
        PH_LINE    = 3'd0,
        PH_COMMENT = 3'd1,
        PH_BETWEEN = 3'd2,
        PH_PLAIN   = 3'd3,
        PH_QUOTED  = 3'd4
    } t_phase;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_POP,
        ST_CMP,
        ST_PUSH,
        ST_TOKB,
        ST_CHAR
    } t_state;

    typedef struct packed {
        t_event_kind          kind;
        logic [CP_W-1:0]      char_value;
        logic [DEPTH_W-1:0]   node_depth;
        logic                 unclosed_quote;
        logic                 depth_overflow;
        logic                 last_of_run;
    } t_event;

endpackage

FILE: rtl/itt_in_if.sv
// itt_in_if: input channel of the tokenizer, one code point per transaction.
// Depends on itt_pkg.
interface itt_in_if import itt_pkg::*; ();
    logic            valid;
    logic            ready;
    logic [CP_W-1:0] code_point;

    modport source (output valid, output code_point, input ready);
    modport sink   (input valid, input code_point, output ready);
endinterface

FILE: rtl/itt_out_if.sv
// itt_out_if: event channel of the tokenizer, one tree event per transaction.
// Depends on itt_pkg.
interface itt_out_if import itt_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [KIND_W-1:0]  event_kind;
    logic [CP_W-1:0]    char_value;
    logic [DEPTH_W-1:0] node_depth;
    logic               unclosed_quote;
    logic               depth_overflow;
    logic               last_of_run;

    modport source (output valid, output event_kind, output char_value, output node_depth,
                    output unclosed_quote, output depth_overflow, output last_of_run,
                    input ready);
    modport sink   (input valid, input event_kind, input char_value, input node_depth,
                    input unclosed_quote, input depth_overflow, input last_of_run,
                    output ready);
endinterface

FILE: rtl/itt_ram.sv
// itt_ram: generic simple dual port RAM, one write and one registered read port.
// No dependencies.
module itt_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/indent_tree_tokenizer.sv
// Events: an event enters the output queue at the end of the cycle that produces it and is
// visible at o_out the next cycle if the queue was empty; a code point that starts no token
// is taken, with any event it makes, in the same cycle. Flow: a plain token start passes the
// token-begin and character states, a quoted one only token-begin; a line's first character
// first passes pop, then compare (repeated while widths pop, skipped on an empty stack), then
// push. A full output queue stalls. Reset: line start, no indentation, empty queue; RAM not cleared.
module indent_tree_tokenizer import itt_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    itt_in_if.sink     i_in,
    itt_out_if.source  o_out
);

    t_state              r_state, n_state;
    t_phase              r_phase, n_phase;
    logic [WHITE_W-1:0]  r_white, n_white;
    logic [LVL_W-1:0]    r_lvl, n_lvl;
    logic                r_bt, n_bt;
    logic [CP_W-1:0]     r_cp, n_cp;

    // Output queue
    t_event              r_fifo [FIFO_DEPTH];
    logic [FPTR_W-1:0]   r_wptr, r_rptr;
    logic [FCNT_W-1:0]   r_cnt;
    logic                fifo_full, push, pop;
    t_event              push_ev;

    // Width RAM
    logic                ram_we;
    logic [ADDR_W-1:0]   ram_waddr, ram_raddr;
    logic [WHITE_W-1:0]  ram_wdata, ram_rdata;

    logic                accept;
    logic [CP_W-1:0]     cp;
    logic                is_nl, is_white, is_hash, is_close;
    logic [LVL_W-1:0]    lvl_m1, lvl_m2;
    logic                stack_full, pop_hit;

    function automatic t_event mk_event(t_event_kind kind, logic [CP_W-1:0] ch,
                                        logic [DEPTH_W-1:0] depth, logic unc,
                                        logic ovf, logic last);
        t_event ev;
        ev.kind           = kind;
        ev.char_value     = ch;
        ev.node_depth     = depth;
        ev.unclosed_quote = unc;
        ev.depth_overflow = ovf;
        ev.last_of_run    = last;
        return ev;
    endfunction

    itt_ram #(
        .WIDTH (WHITE_W),
        .DEPTH (MAX_DEPTH)
    ) u_width_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign fifo_full  = (r_cnt == FCNT_W'(FIFO_DEPTH));
    assign i_in.ready = (r_state == ST_IDLE) && !fifo_full;
    assign accept     = i_in.valid && i_in.ready;
    assign cp         = i_in.code_point;

    assign is_nl    = (cp == CH_NL);
    assign is_white = (cp <= CH_SP);
    assign is_hash  = (cp == CH_HASH);
    assign is_close = (cp == (r_bt ? CH_BT : CH_DQ));

    assign lvl_m1     = r_lvl - LVL_W'(1);
    assign lvl_m2     = r_lvl - LVL_W'(2);
    assign stack_full = (r_lvl == LVL_W'(MAX_DEPTH));
    assign pop_hit    = (ram_rdata >= r_white);

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    unique case (r_phase)
                        PH_COMMENT, PH_PLAIN, PH_QUOTED: n_state = ST_IDLE;
                        PH_BETWEEN: begin
                            if (!is_white && !is_hash) n_state = ST_TOKB;
                        end
                        default: begin
                            if (!is_white && !is_hash) n_state = ST_POP;
                        end
                    endcase
                end
            end
            ST_POP:  n_state = (r_lvl == '0) ? ST_PUSH : ST_CMP;
            ST_CMP: begin
                if (!pop_hit || lvl_m1 == '0) n_state = ST_PUSH;
            end
            ST_PUSH: begin
                if (!fifo_full) n_state = ST_TOKB;
            end
            ST_TOKB: begin
                if (!fifo_full) n_state = (r_cp == CH_DQ || r_cp == CH_BT) ? ST_IDLE : ST_CHAR;
            end
            ST_CHAR: begin
                if (!fifo_full) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Datapath and outputs
    always_comb begin
        n_phase   = r_phase;
        n_white   = r_white;
        n_lvl     = r_lvl;
        n_bt      = r_bt;
        n_cp      = r_cp;
        push      = 1'b0;
        push_ev   = mk_event(EV_TOKEN_END, '0, '0, 1'b0, 1'b0, 1'b1);
        ram_we    = 1'b0;
        ram_waddr = r_lvl[ADDR_W-1:0];
        ram_wdata = r_white;
        ram_raddr = lvl_m1[ADDR_W-1:0];

        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_cp = cp;
                    unique case (r_phase)
                        PH_COMMENT: begin
                            if (is_nl) begin
                                n_phase = PH_LINE;
                                n_white = '0;
                            end
                        end
                        PH_BETWEEN: begin
                            if (is_nl) begin
                                n_phase = PH_LINE;
                                n_white = '0;
                            end else if (!is_white && is_hash) begin
                                n_phase = PH_COMMENT;
                            end
                        end
                        PH_PLAIN: begin
                            push = 1'b1;
                            if (is_nl) begin
                                n_phase = PH_LINE;
                                n_white = '0;
                            end else if (is_white) begin
                                n_phase = PH_BETWEEN;
                            end else begin
                                push_ev = mk_event(EV_TOKEN_CHAR, cp, '0, 1'b0, 1'b0, 1'b1);
                            end
                        end
                        PH_QUOTED: begin
                            push = 1'b1;
                            if (is_nl) begin
                                push_ev = mk_event(EV_TOKEN_END, '0, '0, 1'b1, 1'b0, 1'b1);
                                n_phase = PH_LINE;
                                n_white = '0;
                            end else if (is_close) begin
                                n_phase = PH_BETWEEN;
                            end else begin
                                push_ev = mk_event(EV_TOKEN_CHAR, cp, '0, 1'b0, 1'b0, 1'b1);
                            end
                        end
                        default: begin
                            // line start, also any stray phase code
                            n_phase = PH_LINE;
                            if (is_nl) begin
                                n_white = '0;
                            end else if (is_white) begin
                                if (r_white != WHITE_MAX) n_white = r_white + WHITE_W'(1);
                            end else if (is_hash) begin
                                n_phase = PH_COMMENT;
                            end
                        end
                    endcase
                end
            end
            ST_POP: begin
                ram_raddr = lvl_m1[ADDR_W-1:0];
            end
            ST_CMP: begin
                // read data belongs to entry r_lvl-1; prefetch the one below on a pop
                ram_raddr = lvl_m2[ADDR_W-1:0];
                if (pop_hit) n_lvl = lvl_m1;
            end
            ST_PUSH: begin
                if (!fifo_full) begin
                    push    = 1'b1;
                    ram_we  = 1'b1;
                    n_white = '0;
                    if (stack_full) begin
                        ram_waddr = ADDR_W'(MAX_DEPTH - 1);
                        push_ev   = mk_event(EV_NODE_BEGIN, '0, DEPTH_W'(r_lvl),
                                             1'b0, 1'b1, 1'b0);
                    end else begin
                        n_lvl   = r_lvl + LVL_W'(1);
                        push_ev = mk_event(EV_NODE_BEGIN, '0, DEPTH_W'(r_lvl + LVL_W'(1)),
                                           1'b0, 1'b0, 1'b0);
                    end
                end
            end
            ST_TOKB: begin
                if (!fifo_full) begin
                    push = 1'b1;
                    if (r_cp == CH_DQ || r_cp == CH_BT) begin
                        push_ev = mk_event(EV_TOKEN_BEGIN, '0, '0, 1'b0, 1'b0, 1'b1);
                        n_bt    = (r_cp == CH_BT);
                        n_phase = PH_QUOTED;
                    end else begin
                        push_ev = mk_event(EV_TOKEN_BEGIN, '0, '0, 1'b0, 1'b0, 1'b0);
                    end
                end
            end
            ST_CHAR: begin
                if (!fifo_full) begin
                    push    = 1'b1;
                    push_ev = mk_event(EV_TOKEN_CHAR, r_cp, '0, 1'b0, 1'b0, 1'b1);
                    n_phase = PH_PLAIN;
                end
            end
            default: ;
        endcase
    end

    assign pop = o_out.valid && o_out.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_phase <= PH_LINE;
            r_white <= '0;
            r_lvl   <= '0;
            r_bt    <= 1'b0;
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_phase <= n_phase;
            r_white <= n_white;
            r_lvl   <= n_lvl;
            r_bt    <= n_bt;
            if (push) r_wptr <= r_wptr + FPTR_W'(1);
            if (pop)  r_rptr <= r_rptr + FPTR_W'(1);
            unique case ({push, pop})
                2'b10:   r_cnt <= r_cnt + FCNT_W'(1);
                2'b01:   r_cnt <= r_cnt - FCNT_W'(1);
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_cp <= n_cp;
        if (push) r_fifo[r_wptr] <= push_ev;
    end

    assign o_out.valid          = (r_cnt != '0);
    assign o_out.event_kind     = r_fifo[r_rptr].kind;
    assign o_out.char_value     = r_fifo[r_rptr].char_value;
    assign o_out.node_depth     = r_fifo[r_rptr].node_depth;
    assign o_out.unclosed_quote = r_fifo[r_rptr].unclosed_quote;
    assign o_out.depth_overflow = r_fifo[r_rptr].depth_overflow;
    assign o_out.last_of_run    = r_fifo[r_rptr].last_of_run;

endmodule
